[rtl/gsmc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmc_pkg: shared types, widths and helpers for the marker classifier
// Holds the fixed sizes of the file, sample and group maps, the register
// index codes of the configuration port and the small counting functions.
// ----------------------------------------------------------------------------
package gsmc_pkg;

  // Table sizes, fixed by the packing of the two map registers.
  localparam int FILES    = 16;
  localparam int SAMPLES  = 8;
  localparam int GROUPS   = 4;

  // Field widths.
  localparam int SIDX_W   = 3;                      // sample index per file
  localparam int GIDX_W   = 2;                      // group index per sample
  localparam int FRAC_W   = 9;                      // fractions in 1/256
  localparam int NF_W     = 5;                      // files_used register
  localparam int NS_W     = 4;                      // samples_used register
  localparam int NG_W     = 3;                      // groups_used register
  localparam int HIT_W    = $clog2(FILES + 1);      // files per sample
  localparam int SCNT_W   = $clog2(SAMPLES + 1);    // samples per group
  localparam int STHR_W   = FRAC_W + HIT_W;         // sample threshold
  localparam int GTHR_W   = FRAC_W + SCNT_W;        // group threshold
  localparam int FSMAP_W  = SIDX_W * FILES;
  localparam int SGMAP_W  = GIDX_W * SAMPLES;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FSMAP_W;

  // Register index codes.
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SAMPLE_MAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GROUP_MAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILES_USED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_USED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_USED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FRACTION  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_FRACTION   = 3'd6;

  // Reset values of the registers.
  localparam logic [NF_W-1:0]   FILES_USED_RST      = 5'd16;
  localparam logic [NS_W-1:0]   SAMPLES_USED_RST    = 4'd8;
  localparam logic [NG_W-1:0]   GROUPS_USED_RST     = 3'd4;
  localparam logic [FRAC_W-1:0] SAMPLE_FRACTION_RST = 9'd154;
  localparam logic [FRAC_W-1:0] GROUP_FRACTION_RST  = 9'd256;

  // Tables derived from the configuration, used by the datapath stages.
  typedef struct packed {
    logic [SAMPLES-1:0][FILES-1:0]   sample_mask;  // used files of each sample
    logic [SAMPLES-1:0][STHR_W-1:0]  sample_thr;   // sample_fraction * size
    logic [GROUPS-1:0][SAMPLES-1:0]  group_mask;   // used samples of each group
    logic [GROUPS-1:0][GTHR_W-1:0]   group_thr;    // group_fraction * size
    logic [GROUPS-1:0]               group_used;
  } cfg_tables_t;

  // Number of set bits in a file vector.
  function automatic logic [HIT_W-1:0] count_files(input logic [FILES-1:0] v);
    logic [HIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < FILES; i++) begin
      n = n + HIT_W'(v[i]);
    end
    return n;
  endfunction

  // Number of set bits in a sample vector.
  function automatic logic [SCNT_W-1:0] count_samples(input logic [SAMPLES-1:0] v);
    logic [SCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      n = n + SCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/gsmc_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmc_cfg: configuration registers and derived tables
// Holds the seven registers and turns them, through the table register,
// into per-sample file masks and thresholds and per-group sample masks and
// thresholds, so the datapath only counts hits and compares.
// ----------------------------------------------------------------------------
module gsmc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gsmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gsmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output gsmc_pkg::cfg_tables_t                tables
);
  import gsmc_pkg::*;

  logic [FSMAP_W-1:0] file_sample_map;
  logic [SGMAP_W-1:0] sample_group_map;
  logic [NF_W-1:0]    files_used;
  logic [NS_W-1:0]    samples_used;
  logic [NG_W-1:0]    groups_used;
  logic [FRAC_W-1:0]  sample_fraction;
  logic [FRAC_W-1:0]  group_fraction;

  logic [NF_W-1:0]    nf;
  logic [NS_W-1:0]    ns;
  logic [NG_W-1:0]    ng;
  cfg_tables_t        tables_next;
  logic [SAMPLES-1:0] sample_nonempty;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_sample_map  <= '0;
      sample_group_map <= '0;
      files_used       <= FILES_USED_RST;
      samples_used     <= SAMPLES_USED_RST;
      groups_used      <= GROUPS_USED_RST;
      sample_fraction  <= SAMPLE_FRACTION_RST;
      group_fraction   <= GROUP_FRACTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILE_SAMPLE_MAP:  file_sample_map  <= cfg_data[FSMAP_W-1:0];
        REG_SAMPLE_GROUP_MAP: sample_group_map <= cfg_data[SGMAP_W-1:0];
        REG_FILES_USED:       files_used       <= cfg_data[NF_W-1:0];
        REG_SAMPLES_USED:     samples_used     <= cfg_data[NS_W-1:0];
        REG_GROUPS_USED:      groups_used      <= cfg_data[NG_W-1:0];
        REG_SAMPLE_FRACTION:  sample_fraction  <= cfg_data[FRAC_W-1:0];
        REG_GROUP_FRACTION:   group_fraction   <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts saturate at the table sizes.
  assign nf = (files_used   > NF_W'(FILES))   ? NF_W'(FILES)   : files_used;
  assign ns = (samples_used > NS_W'(SAMPLES)) ? NS_W'(SAMPLES) : samples_used;
  assign ng = (groups_used  > NG_W'(GROUPS))  ? NG_W'(GROUPS)  : groups_used;

  // Derived tables: membership masks, sizes and thresholds.
  always_comb begin
    tables_next = '0;
    for (int s = 0; s < SAMPLES; s++) begin
      for (int i = 0; i < FILES; i++) begin
        tables_next.sample_mask[s][i] = (NF_W'(i) < nf) &&
            (file_sample_map[SIDX_W*i +: SIDX_W] == SIDX_W'(s)) &&
            ((NS_W+1)'(s) < (NS_W+1)'(ns));
      end
      sample_nonempty[s]         = |tables_next.sample_mask[s];
      tables_next.sample_thr[s]  = STHR_W'(sample_fraction) *
                                   STHR_W'(count_files(tables_next.sample_mask[s]));
    end
    for (int g = 0; g < GROUPS; g++) begin
      tables_next.group_used[g] = ((NG_W+1)'(g) < (NG_W+1)'(ng));
      for (int i = 0; i < SAMPLES; i++) begin
        tables_next.group_mask[g][i] = ((NS_W+1)'(i) < (NS_W+1)'(ns)) &&
            (sample_group_map[GIDX_W*i +: GIDX_W] == GIDX_W'(g)) &&
            tables_next.group_used[g];
      end
      // Only samples that own at least one used file count toward the size.
      tables_next.group_thr[g] = GTHR_W'(group_fraction) *
          GTHR_W'(count_samples(tables_next.group_mask[g] & sample_nonempty));
    end
  end

  always_ff @(posedge clk) begin
    tables <= tables_next;
  end

endmodule
`default_nettype wire

[rtl/gsmc_sample.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmc_sample: per-sample hit count and pass test
// Counts the present files of each sample and compares hits * 256 against
// the sample's threshold; registers the pass and any-hit flags per sample.
// ----------------------------------------------------------------------------
module gsmc_sample (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [gsmc_pkg::FILES-1:0]   presence,
  input  wire gsmc_pkg::cfg_tables_t        tables,
  output logic [gsmc_pkg::SAMPLES-1:0]      sample_pass,
  output logic [gsmc_pkg::SAMPLES-1:0]      sample_hit
);
  import gsmc_pkg::*;

  logic [SAMPLES-1:0] sample_pass_next;
  logic [SAMPLES-1:0] sample_hit_next;
  logic [HIT_W-1:0]   hits [SAMPLES];

  // One counter and one compare per sample lane.
  always_comb begin
    for (int s = 0; s < SAMPLES; s++) begin
      hits[s]             = count_files(presence & tables.sample_mask[s]);
      sample_hit_next[s]  = |(presence & tables.sample_mask[s]);
      sample_pass_next[s] = ({1'b0, hits[s], 8'd0} >= (STHR_W+1)'(tables.sample_thr[s]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_pass <= sample_pass_next;
      sample_hit  <= sample_hit_next;
    end
  end

endmodule
`default_nettype wire

[rtl/gsmc_group.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmc_group: per-group pass test and marker decision
// Counts the passing samples of each group against its threshold, checks
// that failing groups have no hits and that exactly one group passes, and
// registers the result beat.
// ----------------------------------------------------------------------------
module gsmc_group (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [gsmc_pkg::SAMPLES-1:0]  sample_pass,
  input  wire logic [gsmc_pkg::SAMPLES-1:0]  sample_hit,
  input  wire gsmc_pkg::cfg_tables_t         tables,
  output logic                               is_marker,
  output logic [gsmc_pkg::GIDX_W-1:0]        marker_group
);
  import gsmc_pkg::*;

  logic [GROUPS-1:0] group_pass;
  logic [GROUPS-1:0] group_spoiled;
  logic [SCNT_W-1:0] pass_cnt [GROUPS];
  logic              one_pass;
  logic [GIDX_W-1:0] found;
  logic              is_marker_next;

  // Group lanes: passing-sample count against threshold, hits of failures.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      pass_cnt[g]      = count_samples(sample_pass & tables.group_mask[g]);
      group_pass[g]    = tables.group_used[g] &&
          ({1'b0, pass_cnt[g], 8'd0} >= (GTHR_W+1)'(tables.group_thr[g]));
      group_spoiled[g] = tables.group_used[g] && !group_pass[g] &&
          (|(sample_hit & tables.group_mask[g]));
    end
  end

  // Exactly one passing group and no failing group with hits.
  always_comb begin
    found = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (group_pass[g]) begin
        found = GIDX_W'(g);
      end
    end
    one_pass       = (group_pass != '0) && ((group_pass & (group_pass - 1'b1)) == '0);
    is_marker_next = one_pass && (group_spoiled == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_marker    <= is_marker_next;
      marker_group <= is_marker_next ? found : '0;
    end
  end

endmodule
`default_nettype wire

[rtl/group_specific_marker_classifier_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// group_specific_marker_classifier_top: marker classifier for presence rows
// Each input beat is a file presence bitmap; each output beat says whether
// the item is specific to exactly one group and which group that is.
//
// Channels: s_axis carries presence_bits in tdata. m_axis carries is_marker
// in tuser and marker_group in tdata. The configuration port writes one
// register per cycle when cfg_we is high; write only while the block is
// empty. The derived tables follow a write through the configuration
// register and the table register. Pipeline: an accepted input beat
// passes the input register, the sample stage register and the output
// register. Throughput: one beat per cycle while m_axis_tready is high;
// each stage holds one beat and loads when it is empty or its beat moves on.
// Stalls: when m_axis_tready is low the output register holds its beat,
// earlier stages keep filling their empty slots, and s_axis_tready drops
// only once all three stages are full.
// Reset: rst empties the pipeline and returns the registers to their
// default values.
// ----------------------------------------------------------------------------
module group_specific_marker_classifier_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // [15:0] presence_bits
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [1:0] marker_group, zero fill
  output logic                                 m_axis_tuser,  // [0] is_marker
  input  wire logic                            cfg_we,
  input  wire logic [gsmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gsmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsmc_pkg::*;

  cfg_tables_t        tables;
  logic [FILES-1:0]   presence;
  logic [SAMPLES-1:0] sample_pass;
  logic [SAMPLES-1:0] sample_hit;
  logic               is_marker;
  logic [GIDX_W-1:0]  marker_group;
  logic               in_valid;
  logic               mid_valid;
  logic               out_valid;
  logic               in_en;
  logic               mid_en;
  logic               out_en;

  gsmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tables    (tables)
  );

  // Pipeline advance: a stage loads when it is empty or its beat moves on.
  assign out_en        = !out_valid || m_axis_tready;
  assign mid_en        = !mid_valid || out_en;
  assign in_en         = !in_valid  || mid_en;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid <= s_axis_tvalid;
      end
      if (mid_en) begin
        mid_valid <= in_valid;
      end
      if (out_en) begin
        out_valid <= mid_valid;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_en) begin
      presence <= s_axis_tdata[FILES-1:0];
    end
  end

  gsmc_sample u_sample (
    .clk         (clk),
    .en          (mid_en),
    .presence    (presence),
    .tables      (tables),
    .sample_pass (sample_pass),
    .sample_hit  (sample_hit)
  );

  gsmc_group u_group (
    .clk          (clk),
    .en           (out_en),
    .sample_pass  (sample_pass),
    .sample_hit   (sample_hit),
    .tables       (tables),
    .is_marker    (is_marker),
    .marker_group (marker_group)
  );

  // Output beat.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = is_marker;
  assign m_axis_tdata  = {{(8 - GIDX_W){1'b0}}, marker_group};

  // A non-marker result always reports group zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("non-marker result with nonzero group");

  // An accepted input beat occupies the input stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_valid)
    else $error("accepted beat lost at input stage");

  // With the output stalled, a beat in the sample stage stays there.
  assert property (@(posedge clk) disable iff (rst)
    (mid_valid && out_valid && !m_axis_tready) |=> mid_valid)
    else $error("sample stage beat dropped during stall");

endmodule
`default_nettype wire
